// ===== design/hlld_pkg.sv =====
// Shared types, fixed-point angle constants and operation codes for the LED duty core.
package hlld_pkg;

	// Angles are unsigned radians, Q16
	localparam int ONE_Q16      = 65536;
	localparam int PI_Q16       = 205887;
	localparam int TWO_PI_Q16   = 411775;
	localparam int THREE_PI_Q16 = 617662;
	localparam int HALF_PI_Q16  = 102944;
	localparam int THIRD_PI_Q16 = 68629;
	localparam int SIXTH_PI_Q16 = 34315;

	// 255 * 32768, the "one" of a trigonometric channel numerator
	localparam int TRIG_BIAS    = 8355840;

	localparam int HUE_COUNT    = 256;

	typedef enum logic [1:0] {
		OP_DIRECT = 2'd0,
		OP_TRIG   = 2'd1,
		OP_FAST   = 2'd2,
		OP_OFF    = 2'd3
	} op_t;

	// Per-hue lookup tables
	typedef logic signed [16:0] sin_tab_t [HUE_COUNT];
	typedef logic [17:0]        fast_tab_t [HUE_COUNT];

	// Hue angle in Q16: floor(hue * 2PI / 255), used at elaboration only
	function automatic int hue_angle(input int hue_code);
		longint prod;
		begin
			prod = longint'(hue_code) * longint'(TWO_PI_Q16);
			return int'(prod / 255);
		end
	endfunction

endpackage

// ===== design/hue_lightness_to_led_duty_core.sv =====
// Color request to active-low RGB PWM duty pipeline (direct, trig HSL, fast HSL, off).
//
// Pipeline: 4 register stages (table read, saturation multiply, lightness multiply,
// divide/clamp/invert); out_valid is the stage 4 valid bit.
// Throughput: one item per cycle; all stages advance together and hold while the
// output register is full and out_ready is low.
// Reset: arst_n clears every stage valid bit; payload registers are not reset.
module hue_lightness_to_led_duty_core
	import hlld_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] hue,
	input  logic [7:0] saturation,
	input  logic [7:0] lightness,
	input  logic [7:0] red_level,
	input  logic [7:0] green_level,
	input  logic [7:0] blue_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red_duty,
	output logic [7:0] green_duty,
	output logic [7:0] blue_duty
);

	// ---------------------------------------------------------------
	// Elaboration-time table builders
	// ---------------------------------------------------------------

	// Full turn in Q16 as a 64-bit constant for the table builders
	localparam longint TURN_Q16 = longint'(TWO_PI_Q16);

	// Odd Taylor series of sin up to x^11 in Q30, rounded to Q15
	function automatic int series_sine(input longint a_q16);
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint r;
		begin
			x    = a_q16 << 14;
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			term = ((term * x2) >> 30) / 6;
			sum  = sum - term;
			term = ((term * x2) >> 30) / 20;
			sum  = sum + term;
			term = ((term * x2) >> 30) / 42;
			sum  = sum - term;
			term = ((term * x2) >> 30) / 72;
			sum  = sum + term;
			term = ((term * x2) >> 30) / 110;
			sum  = sum - term;
			if (sum < 0) begin
				sum = 0;
			end
			r = (sum + 16384) >> 15;
			if (r > 32767) begin
				r = 32767;
			end
			return int'(r);
		end
	endfunction

	// One entry of the Q1.15 sine ROM
	function automatic int rom_entry(input longint k);
		longint a;
		logic   neg;
		int     v;
		begin
			a   = (k * TURN_Q16) / SINE_TABLE_DEPTH;
			neg = 1'b0;
			if (a >= longint'(PI_Q16)) begin
				a   = a - longint'(PI_Q16);
				neg = 1'b1;
			end
			if (a > longint'(HALF_PI_Q16)) begin
				a = longint'(PI_Q16) - a;
			end
			v = series_sine(a);
			return neg ? -v : v;
		end
	endfunction

	// ROM sine of a Q16 angle, nearest index
	function automatic int rom_sin(input longint t);
		longint tr;
		longint idx;
		begin
			tr = t;
			while (tr >= TURN_Q16) begin
				tr = tr - TURN_Q16;
			end
			idx = (tr * SINE_TABLE_DEPTH + longint'(PI_Q16)) / TURN_Q16;
			if (idx >= SINE_TABLE_DEPTH) begin
				idx = 0;
			end
			return rom_entry(idx);
		end
	endfunction

	// Piecewise-linear sine, Q16 signed
	function automatic int fast_sin(input int t);
		begin
			if (t < ONE_Q16) return t;
			if (t < 2 * ONE_Q16) return ONE_Q16;
			if (t < 4 * ONE_Q16) return PI_Q16 - t;
			if (t < 5 * ONE_Q16) return -ONE_Q16;
			if (t < TWO_PI_Q16 + ONE_Q16) return t - TWO_PI_Q16;
			if (t < TWO_PI_Q16 + 2 * ONE_Q16) return ONE_Q16;
			if (t < TWO_PI_Q16 + 4 * ONE_Q16) return THREE_PI_Q16 - t;
			return -ONE_Q16;
		end
	endfunction

	// Per-hue ROM sine at hue angle + offset, optionally negated
	function automatic sin_tab_t build_sin_tab(input int offset, input logic negate);
		sin_tab_t tab;
		int       v;
		begin
			for (int i = 0; i < HUE_COUNT; i++) begin
				v = rom_sin(longint'(hue_angle(i) + offset));
				if (negate) begin
					v = -v;
				end
				tab[i] = 17'(v);
			end
			return tab;
		end
	endfunction

	// Per-hue fast factor 1 +/- fsin, negative values floored at zero
	function automatic fast_tab_t build_fast_tab(input int offset, input logic negate);
		fast_tab_t tab;
		int        f;
		begin
			for (int i = 0; i < HUE_COUNT; i++) begin
				f = fast_sin(hue_angle(i) + offset);
				f = negate ? (ONE_Q16 - f) : (ONE_Q16 + f);
				if (f < 0) begin
					f = 0;
				end
				tab[i] = 18'(f);
			end
			return tab;
		end
	endfunction

	localparam sin_tab_t  SIN_RED    = build_sin_tab(THIRD_PI_Q16 + HALF_PI_Q16, 1'b0);
	localparam sin_tab_t  SIN_GREEN  = build_sin_tab(SIXTH_PI_Q16, 1'b0);
	localparam sin_tab_t  SIN_BLUE   = build_sin_tab(HALF_PI_Q16, 1'b1);
	localparam fast_tab_t FAST_RED   = build_fast_tab(THIRD_PI_Q16 + HALF_PI_Q16, 1'b0);
	localparam fast_tab_t FAST_GREEN = build_fast_tab(SIXTH_PI_Q16, 1'b0);
	localparam fast_tab_t FAST_BLUE  = build_fast_tab(HALF_PI_Q16, 1'b1);

	// ---------------------------------------------------------------
	// Datapath helpers
	// ---------------------------------------------------------------

	// 255*32768 + sat * v; always positive, fits 24 bits
	function automatic logic [23:0] trig_num(input logic [7:0] sat,
			input logic signed [16:0] v);
		logic signed [25:0] prod;
		logic signed [25:0] sum;
		begin
			prod = 26'($signed({1'b0, sat})) * 26'(v);
			sum  = prod + 26'(TRIG_BIAS);
			return sum[23:0];
		end
	endfunction

	// floor(y / 255) for a 16-bit y, estimate plus one correction
	function automatic logic [8:0] div255(input logic [15:0] y);
		logic [16:0] s;
		logic [8:0]  q;
		logic [17:0] rem;
		begin
			s   = {1'b0, y} + 17'(y >> 8);
			q   = s[16:8];
			rem = 18'(y) - (18'(q) << 8) + 18'(q);
			if (rem >= 18'd255) begin
				q = q + 9'd1;
			end
			return q;
		end
	endfunction

	// Channel level from the lightness product, clamped to 0..255
	function automatic logic [7:0] chan_level(input op_t op, input logic [31:0] p);
		logic [8:0] q;
		begin
			if (op == OP_TRIG) begin
				q = div255(p[31:16]);
				return (q > 9'd255) ? 8'hFF : q[7:0];
			end
			return (p[31:17] > 15'd255) ? 8'hFF : p[24:17];
		end
	endfunction

	// Active-low duty per mode
	function automatic logic [7:0] duty_of(input op_t op, input logic [7:0] lvl,
			input logic [31:0] p);
		logic [7:0] d;
		begin
			case (op) inside
				OP_DIRECT:        d = ~lvl;
				OP_TRIG, OP_FAST: d = ~chan_level(op, p);
				default:          d = 8'hFF;
			endcase
			return d;
		end
	endfunction

	// ---------------------------------------------------------------
	// Pipeline control: every stage moves when the output can take data
	// ---------------------------------------------------------------
	logic stage_en;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign stage_en  = !valid_s4 || out_ready;
	assign in_ready  = stage_en;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (stage_en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: per-hue table reads
	// ---------------------------------------------------------------
	op_t                op_s1;
	logic [7:0]         sat_s1, light_s1;
	logic [7:0]         red_lvl_s1, green_lvl_s1, blue_lvl_s1;
	logic signed [16:0] sin_r_s1, sin_g_s1, sin_b_s1;
	logic [17:0]        fast_r_s1, fast_g_s1, fast_b_s1;

	always_ff @(posedge clk) begin
		if (stage_en) begin
			op_s1        <= op_t'(operation);
			sat_s1       <= saturation;
			light_s1     <= lightness;
			red_lvl_s1   <= red_level;
			green_lvl_s1 <= green_level;
			blue_lvl_s1  <= blue_level;
			sin_r_s1     <= SIN_RED[hue];
			sin_g_s1     <= SIN_GREEN[hue];
			sin_b_s1     <= SIN_BLUE[hue];
			fast_r_s1    <= FAST_RED[hue];
			fast_g_s1    <= FAST_GREEN[hue];
			fast_b_s1    <= FAST_BLUE[hue];
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: saturation multiply, pick the lightness multiplicand
	// ---------------------------------------------------------------
	op_t         op_s2;
	logic [7:0]  light_s2;
	logic [7:0]  red_lvl_s2, green_lvl_s2, blue_lvl_s2;
	logic [23:0] opnd_r_s2, opnd_g_s2, opnd_b_s2;

	always_ff @(posedge clk) begin
		if (stage_en) begin
			op_s2        <= op_s1;
			light_s2     <= light_s1;
			red_lvl_s2   <= red_lvl_s1;
			green_lvl_s2 <= green_lvl_s1;
			blue_lvl_s2  <= blue_lvl_s1;
			if (op_s1 == OP_TRIG) begin
				opnd_r_s2 <= trig_num(sat_s1, sin_r_s1);
				opnd_g_s2 <= trig_num(sat_s1, sin_g_s1);
				opnd_b_s2 <= trig_num(sat_s1, sin_b_s1);
			end else begin
				opnd_r_s2 <= 24'(fast_r_s1);
				opnd_g_s2 <= 24'(fast_g_s1);
				opnd_b_s2 <= 24'(fast_b_s1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: lightness multiply
	// ---------------------------------------------------------------
	op_t         op_s3;
	logic [7:0]  red_lvl_s3, green_lvl_s3, blue_lvl_s3;
	logic [31:0] prod_r_s3, prod_g_s3, prod_b_s3;

	always_ff @(posedge clk) begin
		if (stage_en) begin
			op_s3        <= op_s2;
			red_lvl_s3   <= red_lvl_s2;
			green_lvl_s3 <= green_lvl_s2;
			blue_lvl_s3  <= blue_lvl_s2;
			prod_r_s3    <= 32'(light_s2) * 32'(opnd_r_s2);
			prod_g_s3    <= 32'(light_s2) * 32'(opnd_g_s2);
			prod_b_s3    <= 32'(light_s2) * 32'(opnd_b_s2);
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: scale down, clamp, invert into the output register
	// ---------------------------------------------------------------
	op_t op_s4;

	always_ff @(posedge clk) begin
		if (stage_en) begin
			op_s4      <= op_s3;
			red_duty   <= duty_of(op_s3, red_lvl_s3, prod_r_s3);
			green_duty <= duty_of(op_s3, green_lvl_s3, prod_g_s3);
			blue_duty  <= duty_of(op_s3, blue_lvl_s3, prod_b_s3);
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------

	// A held pipeline keeps its stage 1 item
	a_stall_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !stage_en |=> valid_s1)
		else $error("stage 1 item lost during stall");

	// An item in the last work stage reaches the output when the pipe moves
	a_s3_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && stage_en |=> out_valid)
		else $error("item dropped between stage 3 and output");

	// Off mode drives every LED dark
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_s4 == OP_OFF |->
			red_duty == 8'hFF && green_duty == 8'hFF && blue_duty == 8'hFF)
		else $error("off mode output not dark");

	// Trig channels never exceed 254, so duty never reaches zero
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_s4 == OP_TRIG |->
			red_duty != 8'h00 && green_duty != 8'h00 && blue_duty != 8'h00)
		else $error("trig channel out of range");

endmodule
